// ===== design/fcrm_pkg.sv =====
// Package for the four-channel RMS current meter.
// Holds the register codes, reset values, fixed widths and lane types.
// No dependencies.
`default_nettype none

package fcrm_pkg;

   localparam int ACC_BITS    = 40;
   localparam int ROOT_BITS   = ACC_BITS / 2;
   localparam int WINDOW_BITS = 13;
   localparam int VALUE_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_Q8       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFFSET_MA     = 2'd2;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 13'd2000;
   localparam logic [VALUE_BITS-1:0]  GAIN_RESET   = 16'd2063;
   localparam logic [VALUE_BITS-1:0]  OFFSET_RESET = 16'd2750;

   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_DIVIDE,
      LANE_ROOT,
      LANE_SCALE,
      LANE_DONE
   } lane_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lane_stat_type;

endpackage

`default_nettype wire

// ===== design/four_channel_rms_current_meter.sv =====
// RMS current meter over several transformer channels.
// Holds the configuration registers, the window counter, the lanes and the merge stage.
// Depends on fcrm_pkg, fcrm_lane and fcrm_merge.
//
// Each req item carries one raw sample per channel. Every accepted item is squared and
// added to each channel's accumulator in the same cycle, so samples stream at one item
// per cycle while req_tready is high. The item that completes a window hands the sums to
// the lanes, which run a bit-serial divide, a two-bit-per-cycle root and one scaling
// multiply; the merge stage then registers the result and raises rsp_tvalid. Sampling goes
// on meanwhile. req_tready drops only for an item that would complete the next window
// while the lanes are still busy.
// A stalled rsp item holds in the output register; the lanes then wait in their done
// state, which in turn holds back the next window's last item.
// Configuration writes on the csr channel are always taken and should be made while
// no window result is pending. Reset restores the register defaults and clears the
// accumulators, the sample count and the output valid flag; no clearing pass is needed.
`default_nettype none

module four_channel_rms_current_meter #(
   parameter int CHANNELS    = 4,
   parameter int SAMPLE_BITS = 12,
   parameter int MAX_WINDOW  = 4096
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // sample_ch0 .. sample_chN, SAMPLE_BITS each, from the lowest bit up
   input  wire logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // current_ch0_ma .. current_chN_ma, 16 bits each, from the lowest bit up
   output logic [CHANNELS*fcrm_pkg::VALUE_BITS-1:0]     rsp_tdata,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [fcrm_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [fcrm_pkg::VALUE_BITS-1:0]         csr_data
);
   import fcrm_pkg::*;

   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int RSP_W = CHANNELS * VALUE_BITS;

   logic [WINDOW_BITS-1:0] window_ff, window_in;
   logic [VALUE_BITS-1:0]  gain_ff, gain_in;
   logic [VALUE_BITS-1:0]  offset_ff, offset_in;
   logic [WIN_W-1:0]       count_ff, count_in;

   logic [WIN_W-1:0]                     win_eff;
   logic                                 last;
   logic                                 accept;
   logic                                 lanes_busy;
   logic                                 take;
   lane_stat_type [CHANNELS-1:0]         lane_stat;
   logic [CHANNELS-1:0][VALUE_BITS-1:0]  lane_current;

   assign csr_ready = 1'b1;

   always_comb begin
      window_in = window_ff;
      gain_in   = gain_ff;
      offset_in = offset_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_WINDOW_LENGTH: window_in = csr_data[WINDOW_BITS-1:0];
            REG_GAIN_Q8:       gain_in   = csr_data;
            REG_OFFSET_MA:     offset_in = csr_data;
            default:           window_in = window_ff;
         endcase
      end
   end

   always_comb begin
      if (window_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (32'(window_ff) > 32'(MAX_WINDOW)) begin
         win_eff = WIN_W'(MAX_WINDOW);
      end else begin
         win_eff = WIN_W'(window_ff);
      end
   end

   always_comb begin
      lanes_busy = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         lanes_busy = lanes_busy | lane_stat[i].busy;
      end
   end

   assign last       = ({1'b0, count_ff} + 1'b1) >= {1'b0, win_eff};
   assign req_tready = !(last && lanes_busy);
   assign accept     = req_tvalid && req_tready;
   assign count_in   = accept ? (last ? '0 : count_ff + 1'b1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         gain_ff   <= GAIN_RESET;
         offset_ff <= OFFSET_RESET;
         count_ff  <= '0;
      end else begin
         window_ff <= window_in;
         gain_ff   <= gain_in;
         offset_ff <= offset_in;
         count_ff  <= count_in;
      end
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      fcrm_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .WIN_W       (WIN_W)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .sample  (req_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
         .accept  (accept),
         .last    (last),
         .divisor (win_eff),
         .gain    (gain_ff),
         .offset  (offset_ff),
         .take    (take),
         .stat    (lane_stat[g]),
         .current (lane_current[g])
      );
   end

   fcrm_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .lane_stat    (lane_stat),
      .lane_current (lane_current),
      .take         (take),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata[RSP_W-1:0])
   );

endmodule

`default_nettype wire

// ===== design/fcrm_lane.sv =====
// One channel lane: squares and accumulates samples, then divides the window sum,
// takes the integer root and scales it to milliamps on a shadow copy.
// Depends on fcrm_pkg.
`default_nettype none

module fcrm_lane #(
   parameter int SAMPLE_BITS = 12,
   parameter int WIN_W       = 13
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [SAMPLE_BITS-1:0]            sample,
   input  wire logic                              accept,
   input  wire logic                              last,
   input  wire logic [WIN_W-1:0]                  divisor,
   input  wire logic [fcrm_pkg::VALUE_BITS-1:0]   gain,
   input  wire logic [fcrm_pkg::VALUE_BITS-1:0]   offset,
   input  wire logic                              take,
   output fcrm_pkg::lane_stat_type                stat,
   output logic [fcrm_pkg::VALUE_BITS-1:0]        current
);
   import fcrm_pkg::*;

   localparam int CNT_W  = $clog2(ACC_BITS);
   localparam int PROD_W = ROOT_BITS + VALUE_BITS;
   localparam int SCL_W  = PROD_W - 8;

   lane_state_type state_ff, state_in;

   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [ACC_BITS-1:0]    work_ff, work_in;
   logic [WIN_W-1:0]       div_ff, div_in;
   logic [WIN_W-1:0]       drem_ff, drem_in;
   logic [ROOT_BITS+1:0]   rrem_ff, rrem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   logic [SAMPLE_BITS-1:0]   mag;
   logic [2*SAMPLE_BITS-1:0] mag_sq;
   logic [ACC_BITS-1:0]      sum;
   logic                     start;
   logic                     div_step;
   logic                     root_step;
   logic                     scale_step;
   logic [WIN_W:0]           dshift;
   logic                     dge;
   logic [ROOT_BITS+1:0]     rshift;
   logic [ROOT_BITS+1:0]     trial;
   logic                     rge;
   logic [SCL_W-1:0]         scaled;
   logic [SCL_W-1:0]         diff;

   // The magnitude of 2*raw - (2^SAMPLE_BITS - 1) is always odd.
   assign mag = sample[SAMPLE_BITS-1] ? {sample[SAMPLE_BITS-2:0], 1'b1}
                                      : {~sample[SAMPLE_BITS-2:0], 1'b1};
   assign mag_sq = mag * mag;
   assign sum    = acc_ff + ACC_BITS'(mag_sq);
   assign start  = accept && last;

   assign dshift = {drem_ff, work_ff[ACC_BITS-1]};
   assign dge    = dshift >= {1'b0, div_ff};
   assign rshift = {rrem_ff[ROOT_BITS-1:0], work_ff[ACC_BITS-1:ACC_BITS-2]};
   assign trial  = {root_ff, 2'b01};
   assign rge    = rshift >= trial;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LANE_IDLE: begin
            if (start) begin
               state_in = LANE_DIVIDE;
            end
         end
         LANE_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = LANE_ROOT;
            end
         end
         LANE_ROOT: begin
            if (cnt_ff == '0) begin
               state_in = LANE_SCALE;
            end
         end
         LANE_SCALE: begin
            state_in = LANE_DONE;
         end
         LANE_DONE: begin
            if (take) begin
               state_in = LANE_IDLE;
            end
         end
         default: begin
            state_in = LANE_IDLE;
         end
      endcase
   end

   always_comb begin
      div_step   = 1'b0;
      root_step  = 1'b0;
      scale_step = 1'b0;
      stat.busy  = 1'b1;
      stat.done  = 1'b0;
      unique case (state_ff)
         LANE_IDLE:   stat.busy  = 1'b0;
         LANE_DIVIDE: div_step   = 1'b1;
         LANE_ROOT:   root_step  = 1'b1;
         LANE_SCALE:  scale_step = 1'b1;
         LANE_DONE:   stat.done  = 1'b1;
         default:     stat.busy  = 1'b1;
      endcase
   end

   always_comb begin
      acc_in  = acc_ff;
      work_in = work_ff;
      div_in  = div_ff;
      drem_in = drem_ff;
      rrem_in = rrem_ff;
      root_in = root_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         acc_in = last ? '0 : sum;
      end
      if (start && !stat.busy) begin
         work_in = sum;
         div_in  = divisor;
         drem_in = '0;
         rrem_in = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ACC_BITS - 1);
      end
      if (div_step) begin
         work_in = {work_ff[ACC_BITS-2:0], dge};
         drem_in = dge ? WIN_W'(dshift - {1'b0, div_ff}) : dshift[WIN_W-1:0];
         cnt_in  = (cnt_ff == '0) ? CNT_W'(ROOT_BITS - 1) : cnt_ff - 1'b1;
      end
      if (root_step) begin
         work_in = {work_ff[ACC_BITS-3:0], 2'b00};
         rrem_in = rge ? rshift - trial : rshift;
         root_in = {root_ff[ROOT_BITS-2:0], rge};
         cnt_in  = cnt_ff - 1'b1;
      end
      if (scale_step) begin
         prod_in = PROD_W'(root_ff) * PROD_W'(gain);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
      end
      work_ff <= work_in;
      div_ff  <= div_in;
      drem_ff <= drem_in;
      rrem_ff <= rrem_in;
      root_ff <= root_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
   end

   assign scaled = prod_ff[PROD_W-1:8];
   assign diff   = scaled - SCL_W'(offset);

   always_comb begin
      if (scaled <= SCL_W'(offset)) begin
         current = '0;
      end else if (diff > SCL_W'(16'hFFFF)) begin
         current = 16'hFFFF;
      end else begin
         current = diff[VALUE_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== design/fcrm_merge.sv =====
// Merge stage: collects the currents of all lanes into one result item and
// holds it in the output register until the receiver takes it.
// Depends on fcrm_pkg.
`default_nettype none

module fcrm_merge #(
   parameter int CHANNELS = 4
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire fcrm_pkg::lane_stat_type [CHANNELS-1:0]         lane_stat,
   input  wire logic [CHANNELS-1:0][fcrm_pkg::VALUE_BITS-1:0]  lane_current,
   output logic                                                take,
   output logic                                                rsp_tvalid,
   input  wire logic                                           rsp_tready,
   output logic [CHANNELS*fcrm_pkg::VALUE_BITS-1:0]            rsp_tdata
);
   import fcrm_pkg::*;

   logic                               valid_ff, valid_in;
   logic [CHANNELS*VALUE_BITS-1:0]     data_ff, data_in;
   logic                               all_done;

   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
         all_done = all_done & lane_stat[i].done;
      end
   end

   assign take = all_done && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = lane_current;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

// ===== design/fcrm_checker.sv =====
// Port-level checks for the RMS current meter, attached to the top level by bind.
// Depends only on the top level's ports.
`default_nettype none

module fcrm_checker #(
   parameter int RSP_W = 64
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic             csr_ready
);

   // A result item that waits keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // Input is held back only while the lanes are busy, never right after reset.
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready && csr_ready)
      else $error("not ready after reset");

endmodule

bind four_channel_rms_current_meter fcrm_checker #(
   .RSP_W (RSP_W)
) u_fcrm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);

`default_nettype wire
